/* rtl/bdq_pkg.sv */
package bdq_pkg;

   localparam int VALUE_W = 32;

   // operation codes
   localparam logic [2:0] FUNC_PUSH_HEAD = 3'd0;
   localparam logic [2:0] FUNC_PUSH_TAIL = 3'd1;
   localparam logic [2:0] FUNC_POP_HEAD  = 3'd2;
   localparam logic [2:0] FUNC_POP_TAIL  = 3'd3;
   localparam logic [2:0] FUNC_SEARCH    = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]                func;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] popped_value;
      logic                      found;
      logic [1:0]                status;
      logic                      now_empty;
   } rsp_type;

endpackage

/* rtl/bdq_store.sv */
module bdq_store #(
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [bdq_pkg::VALUE_W-1:0]  wr_data,
   input  logic [AW-1:0]                rd_addr,
   output logic [bdq_pkg::VALUE_W-1:0]  rd_data_ff
);

   logic [bdq_pkg::VALUE_W-1:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

endmodule

/* rtl/bounded_deque_with_search.sv */
// Push, no-op and failed pop/search: result strobe in the cycle after transfer,
//   busy stays low, so one request per cycle is taken.
// Pop: registered RAM read, then the result register; busy while in ST_POP.
// Search: one compare per cycle over the stored entries, head to tail, ending
//   at the first match or the last entry; the result is registered after that compare.
// Reset (synchronous) empties the queue; the entry RAM is not cleared.
module bounded_deque_with_search #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bdq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bdq_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SEARCH
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] left_ff, left_in;
   logic signed [bdq_pkg::VALUE_W-1:0] value_ff, value_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   bdq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [bdq_pkg::VALUE_W-1:0] wr_data;
   logic [IW-1:0]               rd_addr;
   logic [bdq_pkg::VALUE_W-1:0] rd_data;

   logic [IW-1:0] head_prev, head_next, tail_prev, tail_next, ptr_next;
   logic          is_full, is_empty, match;

   bdq_store #(
      .DEPTH(CAPACITY)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - IW'(1);
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + IW'(1);
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - IW'(1);
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + IW'(1);
   assign ptr_next  = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + IW'(1);
   assign is_full   = (count_ff == FULL_CNT);
   assign is_empty  = (count_ff == '0);
   // the one shared compare unit of the search walk
   assign match     = ($signed(rd_data) == value_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      value_in      = value_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = head_prev;
      wr_data       = req_data.value;
      rd_addr       = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in                 = req_data.value;
               rsp_data_in.popped_value = '0;
               rsp_data_in.found        = 1'b0;
               rsp_data_in.status       = bdq_pkg::STATUS_OK;
               rsp_data_in.now_empty    = is_empty;
               rsp_strobe_in            = 1'b1;
               unique case (req_data.func)
                  bdq_pkg::FUNC_PUSH_HEAD: begin
                     if (is_full) begin
                        rsp_data_in.status = bdq_pkg::STATUS_PUSH_FULL;
                     end else begin
                        wr_en                 = 1'b1;
                        wr_addr               = head_prev;
                        head_in               = head_prev;
                        count_in              = count_ff + CW'(1);
                        rsp_data_in.now_empty = 1'b0;
                     end
                  end
                  bdq_pkg::FUNC_PUSH_TAIL: begin
                     if (is_full) begin
                        rsp_data_in.status = bdq_pkg::STATUS_PUSH_FULL;
                     end else begin
                        wr_en                 = 1'b1;
                        wr_addr               = tail_ff;
                        tail_in               = tail_next;
                        count_in              = count_ff + CW'(1);
                        rsp_data_in.now_empty = 1'b0;
                     end
                  end
                  bdq_pkg::FUNC_POP_HEAD: begin
                     if (is_empty) begin
                        rsp_data_in.status = bdq_pkg::STATUS_POP_EMPTY;
                     end else begin
                        rd_addr       = head_ff;
                        head_in       = head_next;
                        count_in      = count_ff - CW'(1);
                        rsp_strobe_in = 1'b0;
                        state_in      = ST_POP;
                     end
                  end
                  bdq_pkg::FUNC_POP_TAIL: begin
                     if (is_empty) begin
                        rsp_data_in.status = bdq_pkg::STATUS_POP_EMPTY;
                     end else begin
                        rd_addr       = tail_prev;
                        tail_in       = tail_prev;
                        count_in      = count_ff - CW'(1);
                        rsp_strobe_in = 1'b0;
                        state_in      = ST_POP;
                     end
                  end
                  bdq_pkg::FUNC_SEARCH: begin
                     if (!is_empty) begin
                        rd_addr       = head_ff;
                        ptr_in        = head_next;
                        left_in       = count_ff;
                        rsp_strobe_in = 1'b0;
                        state_in      = ST_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_strobe_in            = 1'b1;
            rsp_data_in.popped_value = $signed(rd_data);
            rsp_data_in.found        = 1'b0;
            rsp_data_in.status       = bdq_pkg::STATUS_OK;
            rsp_data_in.now_empty    = is_empty;
            state_in                 = ST_IDLE;
         end
         ST_SEARCH: begin
            // rd_data holds the entry fetched last cycle
            if (match || left_ff == CW'(1)) begin
               rsp_strobe_in            = 1'b1;
               rsp_data_in.popped_value = '0;
               rsp_data_in.found        = match;
               rsp_data_in.status       = bdq_pkg::STATUS_OK;
               rsp_data_in.now_empty    = is_empty;
               state_in                 = ST_IDLE;
            end else begin
               rd_addr = ptr_ff;
               ptr_in  = ptr_next;
               left_in = left_ff - CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ptr_ff      <= ptr_in;
      left_ff     <= left_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   logic [CW:0] ring_sum;
   logic [CW:0] ring_wrap;

   assign ring_sum  = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign ring_wrap = (ring_sum >= (CW + 1)'(CAPACITY)) ?
                      ring_sum - (CW + 1)'(CAPACITY) : ring_sum;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above capacity");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      tail_ff == IW'(ring_wrap))
      else $error("tail does not match head plus count");

   a_pop_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == bdq_pkg::STATUS_POP_EMPTY |-> rsp_data.now_empty)
      else $error("pop-on-empty reported with nonempty queue");

   a_pop_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !is_empty &&
      (req_data.func == bdq_pkg::FUNC_POP_HEAD || req_data.func == bdq_pkg::FUNC_POP_TAIL)
      |=> busy)
      else $error("pop transfer did not wait for RAM read");

   a_search_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> left_ff != '0 && left_ff <= count_ff)
      else $error("search walk count out of range");
`endif

endmodule

/* bench/tb_bounded_deque_with_search.sv */
`timescale 1ns / 1ps

module tb_bounded_deque_with_search;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 2000;
   localparam int QUIET_TAIL   = 300;
   localparam int DRAIN_CYCLES = DEPTH + 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   // spare opcodes the block treats as no-ops
   localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [2:0]       func;
      logic [31:0]      value;
      int               reps;
      bit               typed;
      bdq_pkg::rsp_type rsp;
   } stim_row_type;

   logic             clock;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   logic             busy;
   bdq_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   bdq_pkg::rsp_type rsp_data;

   bounded_deque_with_search #(.CAPACITY(DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // deque mirror
   logic [31:0] ring [DEPTH];
   int          head_ptr = 0;
   int          tail_ptr = 0;
   int          fill     = 0;

   bdq_pkg::rsp_type pending_rsp [$];
   stim_row_type     plan [$];
   int               mismatches  = 0;
   int               cycle_count = 0;
   int               n_items     = 0;
   int               n_pops      = 0;
   int               n_found     = 0;
   int               n_searches  = 0;
   int               n_full      = 0;
   int               n_empty     = 0;

   function automatic bdq_pkg::rsp_type rsp_of(logic [31:0] pv, logic fnd, logic [1:0] st,
                                               logic emp);
      bdq_pkg::rsp_type r;
      r = {pv, fnd, st, emp};
      return r;
   endfunction

   function automatic void add_row(logic [2:0] f, logic [31:0] v, int reps, bit typed,
                                   bdq_pkg::rsp_type r);
      stim_row_type s;
      s.func  = f;
      s.value = v;
      s.reps  = reps;
      s.typed = typed;
      s.rsp   = r;
      plan.push_back(s);
   endfunction

   function automatic bdq_pkg::rsp_type deque_apply(bdq_pkg::req_type r);
      bdq_pkg::rsp_type o;
      int               k;
      o = '0;
      case (r.func)
         bdq_pkg::FUNC_PUSH_HEAD:
            if (fill >= DEPTH) begin
               o.status = bdq_pkg::STATUS_PUSH_FULL;
            end else begin
               head_ptr = (head_ptr == 0) ? DEPTH - 1 : head_ptr - 1;
               ring[head_ptr] = r.value;
               fill++;
            end
         bdq_pkg::FUNC_PUSH_TAIL:
            if (fill >= DEPTH) begin
               o.status = bdq_pkg::STATUS_PUSH_FULL;
            end else begin
               ring[tail_ptr] = r.value;
               tail_ptr = (tail_ptr + 1) % DEPTH;
               fill++;
            end
         bdq_pkg::FUNC_POP_HEAD:
            if (fill == 0) begin
               o.status = bdq_pkg::STATUS_POP_EMPTY;
            end else begin
               o.popped_value = ring[head_ptr];
               head_ptr = (head_ptr + 1) % DEPTH;
               fill--;
            end
         bdq_pkg::FUNC_POP_TAIL:
            if (fill == 0) begin
               o.status = bdq_pkg::STATUS_POP_EMPTY;
            end else begin
               tail_ptr = (tail_ptr == 0) ? DEPTH - 1 : tail_ptr - 1;
               o.popped_value = ring[tail_ptr];
               fill--;
            end
         bdq_pkg::FUNC_SEARCH:
            for (k = 0; k < fill; k++) begin
               if (ring[(head_ptr + k) % DEPTH] == r.value)
                  o.found = 1'b1;
            end
         default: ;
      endcase
      o.now_empty = (fill == 0);
      return o;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return $urandom_range(0, 15);   // small pool so duplicates occur
         default: return $urandom;
      endcase
   endfunction

   task automatic send(bdq_pkg::req_type r, bit typed, bdq_pkg::rsp_type typed_rsp);
      bdq_pkg::rsp_type pred;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer happens at this edge
      pred = deque_apply(r);
      pending_rsp.push_back(typed ? typed_rsp : pred);
      n_items++;
      if (r.func == bdq_pkg::FUNC_SEARCH) n_searches++;
      if (pred.found) n_found++;
      if (pred.status == bdq_pkg::STATUS_PUSH_FULL) n_full++;
      if (pred.status == bdq_pkg::STATUS_POP_EMPTY) n_empty++;
      if ((r.func == bdq_pkg::FUNC_POP_HEAD || r.func == bdq_pkg::FUNC_POP_TAIL) &&
          pred.status == bdq_pkg::STATUS_OK)
         n_pops++;
   endtask

   task automatic maybe_idle(bit allow);
      if (allow && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic report(string what, bdq_pkg::rsp_type e, bdq_pkg::rsp_type a);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("[%0d] %s: exp pv=%h fnd=%b st=%0d emp=%b, got pv=%h fnd=%b st=%0d emp=%b",
                  cycle_count, what, e.popped_value, e.found, e.status, e.now_empty,
                  a.popped_value, a.found, a.status, a.now_empty);
   endtask

   // result checker and watchdog
   always @(posedge clock) begin
      bdq_pkg::rsp_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_rsp.size());
         $display("** bounded_deque_with_search: FAILED **");
         $finish;
      end else if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected result", '0, rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.popped_value !== e.popped_value || rsp_data.found !== e.found ||
                rsp_data.status !== e.status || rsp_data.now_empty !== e.now_empty)
               report("mismatch", e, rsp_data);
         end
      end
   end

   initial begin
      bdq_pkg::req_type r;
      int               i;
      int               j;
      int               roll;
      int               push_pct;
      bit               quiet;

      add_row(bdq_pkg::FUNC_POP_HEAD, 32'h0, 1, 1'b1,
              rsp_of(32'h0, 1'b0, bdq_pkg::STATUS_POP_EMPTY, 1'b1));
      add_row(bdq_pkg::FUNC_POP_TAIL, 32'h0, 1, 1'b1,
              rsp_of(32'h0, 1'b0, bdq_pkg::STATUS_POP_EMPTY, 1'b1));
      add_row(bdq_pkg::FUNC_SEARCH, 32'h0, 1, 1'b1,
              rsp_of(32'h0, 1'b0, bdq_pkg::STATUS_OK, 1'b1));
      add_row(FUNC_SPARE_FIRST, 32'hFFFF_FFFF, 1, 1'b1,
              rsp_of(32'h0, 1'b0, bdq_pkg::STATUS_OK, 1'b1));
      add_row(bdq_pkg::FUNC_PUSH_HEAD, 32'h7FFF_FFFF, 1, 1'b1,
              rsp_of(32'h0, 1'b0, bdq_pkg::STATUS_OK, 1'b0));
      add_row(bdq_pkg::FUNC_PUSH_TAIL, 32'h8000_0000, 1, 1'b1,
              rsp_of(32'h0, 1'b0, bdq_pkg::STATUS_OK, 1'b0));
      add_row(bdq_pkg::FUNC_SEARCH, 32'h8000_0000, 1, 1'b1,
              rsp_of(32'h0, 1'b1, bdq_pkg::STATUS_OK, 1'b0));
      add_row(bdq_pkg::FUNC_SEARCH, 32'hFFFF_FFFF, 1, 1'b1,
              rsp_of(32'h0, 1'b0, bdq_pkg::STATUS_OK, 1'b0));
      // fill to capacity, value increments per repeat
      add_row(bdq_pkg::FUNC_PUSH_TAIL, 32'h1, DEPTH - 2, 1'b0, '0);
      add_row(bdq_pkg::FUNC_PUSH_HEAD, 32'h5, 1, 1'b1,
              rsp_of(32'h0, 1'b0, bdq_pkg::STATUS_PUSH_FULL, 1'b0));
      add_row(bdq_pkg::FUNC_PUSH_TAIL, 32'h5, 1, 1'b1,
              rsp_of(32'h0, 1'b0, bdq_pkg::STATUS_PUSH_FULL, 1'b0));
      // last entry: full-length walk
      add_row(bdq_pkg::FUNC_SEARCH, 32'(DEPTH - 2), 1, 1'b0, '0);
      add_row(bdq_pkg::FUNC_POP_HEAD, 32'h0, 1, 1'b1,
              rsp_of(32'h7FFF_FFFF, 1'b0, bdq_pkg::STATUS_OK, 1'b0));
      add_row(bdq_pkg::FUNC_POP_TAIL, 32'h0, 1, 1'b0, '0);
      add_row(bdq_pkg::FUNC_SEARCH, 32'h7FFF_FFFF, 1, 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[p]) begin
         for (j = 0; j < plan[p].reps; j++) begin
            r.func  = plan[p].func;
            r.value = plan[p].value + j;
            send(r, plan[p].typed, plan[p].rsp);
            maybe_idle(1'b1);
         end
      end

      // random part: phases of 100 alternate push-heavy, pop-heavy, balanced
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
         if (i % 500 == 250) begin
            start <= 1'b0;
            do begin
               @(posedge clock);
            end while (pending_rsp.size() != 0);
         end
         case ((i / 100) % 3)
            0:       push_pct = 70;
            1:       push_pct = 30;
            default: push_pct = 50;
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            r.func  = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
            r.value = $urandom;
         end else if (roll < 23) begin
            r.func = bdq_pkg::FUNC_SEARCH;
            if (fill > 0 && $urandom_range(0, 1) == 1)
               r.value = ring[(head_ptr + $urandom_range(0, fill - 1)) % DEPTH];
            else
               r.value = pick_value();
         end else if ($urandom_range(0, 99) < push_pct) begin
            r.func  = $urandom_range(0, 1) ? bdq_pkg::FUNC_PUSH_TAIL : bdq_pkg::FUNC_PUSH_HEAD;
            r.value = pick_value();
         end else begin
            r.func  = $urandom_range(0, 1) ? bdq_pkg::FUNC_POP_TAIL : bdq_pkg::FUNC_POP_HEAD;
            r.value = $urandom;
         end
         send(r, 1'b0, '0);
         maybe_idle(!quiet);
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests: %0d good pops, %0d searches (%0d hits)",
               n_items, n_pops, n_searches, n_found);
      $display("error cases: %0d pushes on full, %0d pops on empty; %0d mismatches",
               n_full, n_empty, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("** bounded_deque_with_search: PASSED **");
      else
         $display("** bounded_deque_with_search: FAILED **");
      $finish;
   end

endmodule
